// File: hdl/udp_echo_time_responder_core_defines.svh
// Assertion macros shared by the responder RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef UDP_ECHO_TIME_RESPONDER_CORE_DEFINES_SVH
`define UDP_ECHO_TIME_RESPONDER_CORE_DEFINES_SVH

`ifndef ASSERT_OFF

// Clocked assertion, switched off while reset is asserted.
`define UETR_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define UETR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define UETR_ASSERT(lbl, clk, rst_n, prop, msg)
`define UETR_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// File: hdl/uetr_pkg.sv
// Shared types, codes and one's-complement helpers of the responder.
// Depends on nothing; used by every module of the block.
package uetr_pkg;

    // Operation codes of an input item.
    localparam logic OP_START = 1'b0;
    localparam logic OP_WORD  = 1'b1;

    // Result kinds.
    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_HEADER  = 2'd1;
    localparam logic [1:0] KIND_VERDICT = 2'd2;

    // Verdict codes.
    localparam logic [1:0] VERD_READY    = 2'd0;
    localparam logic [1:0] VERD_MISMATCH = 2'd1;
    localparam logic [1:0] VERD_NO_PORT  = 2'd2;

    // Configuration register indexes.
    localparam int          CFG_IDX_W     = 4;
    localparam logic [3:0]  CFG_ECHO_PORT = 4'd0;
    localparam logic [3:0]  CFG_TIME_PORT = 4'd1;
    localparam logic [15:0] ECHO_PORT_RST = 16'd7;
    localparam logic [15:0] TIME_PORT_RST = 16'd37;

    // UDP header word positions.
    localparam logic [1:0] HW_SRC_PORT = 2'd0;
    localparam logic [1:0] HW_DST_PORT = 2'd1;
    localparam logic [1:0] HW_LENGTH   = 2'd2;
    localparam logic [1:0] HW_CHECKSUM = 2'd3;

    localparam logic [14:0] HDR_WORDS      = 15'd4;
    localparam logic [14:0] WORD_COUNT_MAX = 15'h7FFF;
    localparam logic [15:0] PROTO_UDP      = 16'd17;
    localparam logic [15:0] TIME_REPLY_LEN = 16'd12;

    localparam int FIFO_DEPTH_DEF = 4;

    // Reply form chosen at the end of a datagram.
    typedef enum logic [1:0] {
        RP_MISMATCH,
        RP_ECHO,
        RP_TIME,
        RP_NONE
    } t_reply;

    // Back end sequencer states.
    typedef enum logic [1:0] {
        BK_ECHO,
        BK_SUM,
        BK_EMIT
    } t_back_state;

    // One unit of work handed from the front end to the back end.
    typedef struct packed {
        logic        has_echo;
        logic        final_word;
        logic [14:0] echo_pos;
        logic [15:0] echo_word;
        logic [15:0] pseudo_sum;
        logic [15:0] req_length;
        logic [15:0] peer_port;
        logic [15:0] hdr_sum;
        logic [15:0] payload_sum;
        logic [15:0] rx_checksum;
        logic [31:0] held_time;
        logic        echo_match;
        logic        time_match;
    } t_job;

    // Add two words with end-around carry.
    function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[15:0] + {15'd0, s[16]};
    endfunction

    // Fold a sum of up to seven words back into sixteen bits.
    function automatic logic [15:0] oc_fold19(input logic [18:0] s);
        logic [16:0] f;
        f = {1'b0, s[15:0]} + {14'd0, s[18:16]};
        return f[15:0] + {15'd0, f[16]};
    endfunction

    // Complement a sum into a checksum, zero being sent as all ones.
    function automatic logic [15:0] oc_finish(input logic [15:0] sum);
        logic [15:0] c;
        c = ~sum;
        return (c == 16'd0) ? 16'hFFFF : c;
    endfunction

endpackage

// File: hdl/uetr_front.sv
// Front end: accepts start and word items, keeps the running sums and
// header fields, and hands echo and end-of-datagram work to the queue.
// Depends on uetr_pkg.
module uetr_front
    import uetr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_operation,
    input  logic [31:0] i_src_address,
    input  logic [31:0] i_dst_address,
    input  logic [15:0] i_datagram_length,
    input  logic [31:0] i_current_time,
    input  logic [15:0] i_data_word,
    input  logic        i_last_word,
    input  logic [15:0] i_echo_port,
    input  logic [15:0] i_time_port,
    input  logic        i_q_full,
    output logic        o_push,
    output t_job        o_job
);

    // Datagram context.
    logic        r_active, n_active;
    logic        r_full, n_full;
    logic [14:0] r_count, n_count;
    logic [15:0] r_pseudo, n_pseudo;
    logic [15:0] r_reqlen, n_reqlen;
    logic [31:0] r_time, n_time;
    logic [15:0] r_src, n_src;
    logic [15:0] r_dst, n_dst;
    logic [15:0] r_rxck, n_rxck;
    logic [15:0] r_hsum, n_hsum;
    logic [15:0] r_payload, n_payload;

    logic        accept;
    logic        take_word;
    logic        echo;
    logic        finish_dg;
    logic [15:0] word_m;
    logic [18:0] pseudo_raw;

    assign o_in_ready = !i_q_full;
    assign accept     = i_in_valid && o_in_ready;
    assign take_word  = accept && (i_operation == OP_WORD) && r_active;

    // Address and protocol part of the pseudo-header, summed in one go.
    assign pseudo_raw = {3'd0, i_src_address[31:16]} + {3'd0, i_src_address[15:0]}
                      + {3'd0, i_dst_address[31:16]} + {3'd0, i_dst_address[15:0]}
                      + {3'd0, PROTO_UDP};

    // Update of the context for the item on the input.
    always_comb begin
        n_active  = r_active;
        n_full    = r_full;
        n_count   = r_count;
        n_pseudo  = r_pseudo;
        n_reqlen  = r_reqlen;
        n_time    = r_time;
        n_src     = r_src;
        n_dst     = r_dst;
        n_rxck    = r_rxck;
        n_hsum    = r_hsum;
        n_payload = r_payload;
        echo      = 1'b0;
        finish_dg = 1'b0;
        word_m    = i_data_word;
        if (accept && (i_operation == OP_START)) begin
            n_pseudo  = oc_fold19(pseudo_raw);
            n_reqlen  = i_datagram_length;
            n_time    = i_current_time;
            n_src     = 16'd0;
            n_dst     = 16'd0;
            n_rxck    = 16'd0;
            n_hsum    = 16'd0;
            n_payload = 16'd0;
            n_count   = 15'd0;
            n_full    = 1'b0;
            n_active  = 1'b1;
        end else if (take_word) begin
            if (!r_full) begin
                if (r_count < HDR_WORDS) begin
                    case (r_count[1:0])
                        HW_SRC_PORT: n_src  = i_data_word;
                        HW_DST_PORT: n_dst  = i_data_word;
                        HW_LENGTH:   n_src  = r_src;
                        HW_CHECKSUM: n_rxck = i_data_word;
                        default:     n_src  = r_src;
                    endcase
                    // The checksum field counts as zero.
                    if (r_count[1:0] != HW_CHECKSUM) begin
                        n_hsum = oc_add(r_hsum, i_data_word);
                    end
                end else if ({r_count, 1'b0} < r_reqlen) begin
                    // An odd final byte is padded with zero.
                    if ({r_count, 1'b1} == r_reqlen) begin
                        word_m = {i_data_word[15:8], 8'd0};
                    end
                    n_payload = oc_add(r_payload, word_m);
                    echo      = (r_dst == i_echo_port);
                end
                if (r_count == WORD_COUNT_MAX) begin
                    n_full = 1'b1;
                end else begin
                    n_count = r_count + 15'd1;
                end
            end
            if (i_last_word) begin
                n_active  = 1'b0;
                finish_dg = 1'b1;
            end
        end
    end

    // Job handed to the back end, carrying the closing context.
    always_comb begin
        o_push             = echo || finish_dg;
        o_job.has_echo     = echo;
        o_job.final_word   = finish_dg;
        o_job.echo_pos     = r_count;
        o_job.echo_word    = word_m;
        o_job.pseudo_sum   = r_pseudo;
        o_job.req_length   = r_reqlen;
        o_job.peer_port    = n_src;
        o_job.hdr_sum      = n_hsum;
        o_job.payload_sum  = n_payload;
        o_job.rx_checksum  = n_rxck;
        o_job.held_time    = r_time;
        o_job.echo_match   = (n_dst == i_echo_port);
        o_job.time_match   = (n_dst == i_time_port);
    end

    // Context registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active  <= 1'b0;
            r_full    <= 1'b0;
            r_count   <= 15'd0;
            r_pseudo  <= 16'd0;
            r_reqlen  <= 16'd0;
            r_time    <= 32'd0;
            r_src     <= 16'd0;
            r_dst     <= 16'd0;
            r_rxck    <= 16'd0;
            r_hsum    <= 16'd0;
            r_payload <= 16'd0;
        end else begin
            r_active  <= n_active;
            r_full    <= n_full;
            r_count   <= n_count;
            r_pseudo  <= n_pseudo;
            r_reqlen  <= n_reqlen;
            r_time    <= n_time;
            r_src     <= n_src;
            r_dst     <= n_dst;
            r_rxck    <= n_rxck;
            r_hsum    <= n_hsum;
            r_payload <= n_payload;
        end
    end

endmodule

// File: hdl/uetr_queue.sv
// Short job queue between the front end and the back end.
// Depends on uetr_pkg for the job type.
module uetr_queue
    import uetr_pkg::*;
#(
    parameter int DEPTH = FIFO_DEPTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output logic o_full,
    output logic o_valid,
    output t_job o_head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    assign o_full  = (r_cnt == CNT_FULL);
    assign o_valid = (r_cnt != '0);
    assign o_head  = r_mem[r_rd];

    // Pointer and fill count update.
    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == PTR_LAST) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == PTR_LAST) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    // Job storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

endmodule

// File: hdl/uetr_back.sv
// Back end: turns queued jobs into result transfers, checks the checksum
// and sequences the reply header, time words and verdict.
// Depends on uetr_pkg and the assertion macro header.
`include "udp_echo_time_responder_core_defines.svh"

module uetr_back
    import uetr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_q_valid,
    input  t_job        i_head,
    output logic        o_pop,
    input  logic [15:0] i_echo_port,
    input  logic [15:0] i_time_port,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_out_kind,
    output logic [14:0] o_out_position,
    output logic [15:0] o_out_word,
    output logic [1:0]  o_verdict,
    output logic [15:0] o_reply_length,
    output logic        o_out_last
);

    t_back_state r_state, n_state;
    t_reply      r_reply, n_reply;
    logic [2:0]  r_seq, n_seq;
    logic [15:0] r_rsum, n_rsum;

    // Output register.
    logic        r_ov, n_ov;
    logic [1:0]  r_kind, n_kind;
    logic [14:0] r_pos, n_pos;
    logic [15:0] r_word, n_word;
    logic [1:0]  r_verd, n_verd;
    logic [15:0] r_len, n_len;
    logic        r_last, n_last;

    logic        out_free;
    logic        ld;
    logic        seq_end;
    logic [2:0]  seq_last;
    logic [15:0] computed;
    logic        mismatch;
    logic [18:0] echo_raw;
    logic [18:0] time_raw;

    assign out_free = !r_ov || i_out_ready;

    // Checksum of the request and the two candidate reply checksums.
    assign computed = oc_finish(oc_fold19(
        {3'd0, i_head.pseudo_sum} + {3'd0, i_head.req_length}
        + {3'd0, i_head.hdr_sum} + {3'd0, i_head.payload_sum}));
    assign mismatch = (i_head.rx_checksum != 16'd0) && (i_head.rx_checksum != computed);
    assign echo_raw = {3'd0, i_head.pseudo_sum} + {3'd0, i_head.req_length}
                    + {3'd0, i_echo_port} + {3'd0, i_head.peer_port}
                    + {3'd0, i_head.req_length} + {3'd0, i_head.payload_sum};
    assign time_raw = {3'd0, i_head.pseudo_sum} + {3'd0, TIME_REPLY_LEN}
                    + {3'd0, i_time_port} + {3'd0, i_head.peer_port}
                    + {3'd0, TIME_REPLY_LEN} + {3'd0, i_head.held_time[31:16]}
                    + {3'd0, i_head.held_time[15:0]};

    // Index of the final result of the chosen reply.
    always_comb begin
        case (r_reply)
            RP_ECHO: seq_last = 3'd4;
            RP_TIME: seq_last = 3'd6;
            default: seq_last = 3'd0;
        endcase
    end
    assign seq_end = (r_seq == seq_last);

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_ECHO: begin
                if (i_q_valid && i_head.final_word && (!i_head.has_echo || out_free)) begin
                    n_state = BK_SUM;
                end
            end
            BK_SUM: n_state = BK_EMIT;
            BK_EMIT: begin
                if (out_free && seq_end) begin
                    n_state = BK_ECHO;
                end
            end
            default: n_state = BK_ECHO;
        endcase
    end

    // Result generation and queue pops.
    always_comb begin
        ld      = 1'b0;
        o_pop   = 1'b0;
        n_seq   = r_seq;
        n_reply = r_reply;
        n_rsum  = r_rsum;
        n_kind  = KIND_PAYLOAD;
        n_pos   = 15'd0;
        n_word  = 16'd0;
        n_verd  = VERD_READY;
        n_len   = 16'd0;
        n_last  = 1'b0;
        case (r_state)
            BK_ECHO: begin
                if (i_q_valid && i_head.has_echo && out_free) begin
                    ld     = 1'b1;
                    n_pos  = i_head.echo_pos;
                    n_word = i_head.echo_word;
                    n_last = !i_head.final_word;
                    o_pop  = !i_head.final_word;
                end
            end
            BK_SUM: begin
                n_seq = 3'd0;
                if (mismatch) begin
                    n_reply = RP_MISMATCH;
                end else if (i_head.echo_match) begin
                    n_reply = RP_ECHO;
                end else if (i_head.time_match) begin
                    n_reply = RP_TIME;
                end else begin
                    n_reply = RP_NONE;
                end
                n_rsum = oc_finish(oc_fold19(i_head.echo_match ? echo_raw : time_raw));
            end
            BK_EMIT: begin
                if (out_free) begin
                    ld     = 1'b1;
                    o_pop  = seq_end;
                    n_seq  = r_seq + 3'd1;
                    n_last = seq_end;
                    n_pos  = {12'd0, r_seq};
                    n_kind = KIND_HEADER;
                    case (r_seq)
                        3'd0: n_word = (r_reply == RP_ECHO) ? i_echo_port : i_time_port;
                        3'd1: n_word = i_head.peer_port;
                        3'd2: n_word = (r_reply == RP_ECHO) ? i_head.req_length
                                                            : TIME_REPLY_LEN;
                        3'd3: n_word = r_rsum;
                        3'd4: n_word = i_head.held_time[31:16];
                        3'd5: n_word = i_head.held_time[15:0];
                        default: n_word = 16'd0;
                    endcase
                    if (seq_end) begin
                        // Closing verdict of the datagram.
                        n_kind = KIND_VERDICT;
                        n_pos  = 15'd0;
                        n_word = 16'd0;
                        case (r_reply)
                            RP_MISMATCH: n_verd = VERD_MISMATCH;
                            RP_ECHO: begin
                                n_verd = VERD_READY;
                                n_len  = i_head.req_length;
                            end
                            RP_TIME: begin
                                n_verd = VERD_READY;
                                n_len  = TIME_REPLY_LEN;
                            end
                            default: n_verd = VERD_NO_PORT;
                        endcase
                    end else if (r_seq > 3'd3) begin
                        n_kind = KIND_PAYLOAD;
                    end
                end
            end
            default: ld = 1'b0;
        endcase
    end

    assign n_ov = ld ? 1'b1 : (r_ov && !i_out_ready);

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_ECHO;
            r_ov    <= 1'b0;
            r_seq   <= 3'd0;
            r_reply <= RP_NONE;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
            r_seq   <= n_seq;
            r_reply <= n_reply;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_rsum <= n_rsum;
        if (ld) begin
            r_kind <= n_kind;
            r_pos  <= n_pos;
            r_word <= n_word;
            r_verd <= n_verd;
            r_len  <= n_len;
            r_last <= n_last;
        end
    end

    assign o_out_valid    = r_ov;
    assign o_out_kind     = r_kind;
    assign o_out_position = r_pos;
    assign o_out_word     = r_word;
    assign o_verdict      = r_verd;
    assign o_reply_length = r_len;
    assign o_out_last     = r_last;

    // A job is only retired while one is at the queue head.
    `UETR_ASSERT(a_pop_has_job, i_clk, i_rst_n, o_pop |-> i_q_valid, "pop from empty queue")
    // The reply sequence works on a job that stays at the head.
    `UETR_ASSERT(a_head_held, i_clk, i_rst_n, (r_state != BK_ECHO) |-> i_q_valid, "reply without job")
    // A verdict always closes the results of its item.
    `UETR_ASSERT(a_verdict_last, i_clk, i_rst_n, (r_ov && (r_kind == KIND_VERDICT)) |-> r_last, "verdict not last")
    // The sequence index never runs past the longest reply.
    `UETR_ASSERT(a_seq_range, i_clk, i_rst_n, (r_state == BK_EMIT) |-> (r_seq <= 3'd6), "sequence overrun")

endmodule

// File: hdl/udp_echo_time_responder_core.sv
// Top level of the UDP echo and time responder: configuration registers,
// front end, job queue and back end. Depends on uetr_pkg and the submodules.
//
//  Channel  | Handshake                    | Content
//  ---------+------------------------------+----------------------------------------
//  input    | i_in_valid / o_in_ready      | operation, addresses, length, time, word
//  result   | o_out_valid / i_out_ready    | kind, position, word, verdict, length
//  config   | i_cfg_valid / o_cfg_ready    | register index, 16-bit data
//
// Words are taken one per cycle while the queue has room; the front end updates
// its sums with one end-around-carry add per word. The final word of a datagram
// holds the back end at the queue head through the checksum state and then while
// it emits one reply result per cycle when the output is free (one to seven),
// absorbed by a queue of FIFO_DEPTH jobs. The input stalls only while it is full.
// Reset is synchronous and needs no clearing pass; configuration is always ready.
module udp_echo_time_responder_core
    import uetr_pkg::*;
#(
    parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic                 i_operation,
    input  logic [31:0]          i_src_address,
    input  logic [31:0]          i_dst_address,
    input  logic [15:0]          i_datagram_length,
    input  logic [31:0]          i_current_time,
    input  logic [15:0]          i_data_word,
    input  logic                 i_last_word,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [1:0]           o_out_kind,
    output logic [14:0]          o_out_position,
    output logic [15:0]          o_out_word,
    output logic [1:0]           o_verdict,
    output logic [15:0]          o_reply_length,
    output logic                 o_out_last,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [15:0]          i_cfg_data
);

    logic [15:0] r_echo_port;
    logic [15:0] r_time_port;
    logic        q_full;
    logic        q_valid;
    logic        push;
    logic        pop;
    t_job        job;
    t_job        head;

    // Configuration registers; writes to other indexes are dropped.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_echo_port <= ECHO_PORT_RST;
            r_time_port <= TIME_PORT_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_ECHO_PORT: r_echo_port <= i_cfg_data;
                CFG_TIME_PORT: r_time_port <= i_cfg_data;
                default:       r_echo_port <= r_echo_port;
            endcase
        end
    end

    // Front end.
    uetr_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_operation       (i_operation),
        .i_src_address     (i_src_address),
        .i_dst_address     (i_dst_address),
        .i_datagram_length (i_datagram_length),
        .i_current_time    (i_current_time),
        .i_data_word       (i_data_word),
        .i_last_word       (i_last_word),
        .i_echo_port       (r_echo_port),
        .i_time_port       (r_time_port),
        .i_q_full          (q_full),
        .o_push            (push),
        .o_job             (job)
    );

    // Job queue.
    uetr_queue #(
        .DEPTH (FIFO_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_head  (head)
    );

    // Back end.
    uetr_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (q_valid),
        .i_head         (head),
        .o_pop          (pop),
        .i_echo_port    (r_echo_port),
        .i_time_port    (r_time_port),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_out_kind     (o_out_kind),
        .o_out_position (o_out_position),
        .o_out_word     (o_out_word),
        .o_verdict      (o_verdict),
        .o_reply_length (o_reply_length),
        .o_out_last     (o_out_last)
    );

endmodule
